/* design/ptw_pkg.sv */
`default_nettype none

package ptw_pkg;

  // Descriptor store geometry. The depth must be a power of two so that the
  // word index is a plain slice of the byte address.
  localparam int unsigned STORE_WORDS = 16384;
  localparam int unsigned IDX_W       = $clog2(STORE_WORDS);

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Item modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_WALK  = 1'b1;

  // Descriptor type codes in bits [1:0].
  localparam logic [1:0] DESC_FAULT = 2'd0;
  localparam logic [1:0] L1_COARSE  = 2'd1;
  localparam logic [1:0] L1_SECTION = 2'd2;
  localparam logic [1:0] L2_LARGE   = 2'd1;
  localparam logic [1:0] L2_SMALL   = 2'd2;
  localparam logic [1:0] DESC_PASS  = 2'd3;

  // Result outcome codes.
  typedef enum logic [2:0] {
    OUT_SECTION = 3'd0,
    OUT_LARGE   = 3'd1,
    OUT_SMALL   = 3'd2,
    OUT_FAULT   = 3'd3,
    OUT_PASS    = 3'd4
  } outcome_e;

  // Walk engine states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_L1   = 3'b010,
    ST_L2   = 3'b100
  } walk_state_e;

  // One queued item: a store write or a walk with its first-level index.
  // For a write, word holds the descriptor; for a walk, the virtual address.
  typedef struct packed {
    logic             walk;
    logic [IDX_W-1:0] idx;
    logic [31:0]      word;
  } ptw_entry_t;

  // Handshake between the queue and the back.
  typedef struct packed {
    logic       avail;
    ptw_entry_t head;
  } ptw_qhead_t;

endpackage

`default_nettype wire

/* design/ptw_front.sv */
`default_nettype none

module ptw_front
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  input  wire logic        mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] data_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output ptw_entry_t       q_entry_o
);

  logic [31:0] table_base_q;
  logic [31:0] l1_byte;

  // Translation table base register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
    end else if (cfg_valid_i) begin
      table_base_q <= cfg_data_i;
    end
  end

  // First-level descriptor address, with 32-bit wrap.
  assign l1_byte = table_base_q + {18'd0, address_i[31:20], 2'b00};

  // Classify the item and hand it to the queue.
  always_comb begin
    q_entry_o.walk = (mode_i == MODE_WALK);
    if (mode_i == MODE_WALK) begin
      q_entry_o.idx  = l1_byte[IDX_W+1:2];
      q_entry_o.word = address_i;
    end else begin
      q_entry_o.idx  = address_i[IDX_W+1:2];
      q_entry_o.word = data_i;
    end
  end

  assign q_push_o = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

/* design/ptw_queue.sv */
`default_nettype none

module ptw_queue
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire ptw_entry_t  entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output ptw_qhead_t       head_o
);

  ptw_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  assign head_o.avail = (count_q != '0);
  assign head_o.head  = slot_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

/* design/ptw_back.sv */
`default_nettype none

module ptw_back
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ptw_qhead_t  qhead_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      phys_addr_o,
  output logic [2:0]       outcome_o
);

  walk_state_e      state_q, state_d;
  logic [31:0]      store_q [STORE_WORDS];
  logic [31:0]      rdata_q;
  logic [31:0]      va_q, va_d;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_addr;
  logic [31:0]      l2_byte;
  logic             res_valid;
  logic [31:0]      res_pa;
  outcome_e         res_kind;
  logic             out_free;
  logic             out_valid_q;
  logic [31:0]      phys_q;
  outcome_e         outcome_q;

  assign out_free = !out_valid_q || !out_stall_i;

  // Second-level descriptor address from a coarse table pointer.
  assign l2_byte = {rdata_q[31:9], 9'd0} + {22'd0, va_q[19:12], 2'b00};

  // Walk sequencer: at most one store access per cycle; it waits while the output is stalled.
  always_comb begin
    state_d   = state_q;
    va_d      = va_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = qhead_i.head.idx;
    res_valid = 1'b0;
    res_pa    = '1;
    res_kind  = OUT_FAULT;
    unique case (state_q)
      ST_IDLE: begin
        if (qhead_i.avail) begin
          pop_o = 1'b1;
          if (qhead_i.head.walk) begin
            mem_re  = 1'b1;
            va_d    = qhead_i.head.word;
            state_d = ST_L1;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_L1: begin
        unique case (rdata_q[1:0])
          DESC_FAULT: begin
            res_valid = 1'b1;
          end
          L1_SECTION: begin
            res_valid = 1'b1;
            res_pa    = {rdata_q[31:20], va_q[19:0]};
            res_kind  = OUT_SECTION;
          end
          L1_COARSE: begin
            mem_re   = 1'b1;
            mem_addr = l2_byte[IDX_W+1:2];
            state_d  = ST_L2;
          end
          default: begin
            res_valid = 1'b1;
            res_pa    = va_q;
            res_kind  = OUT_PASS;
          end
        endcase
        if (res_valid && out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_L2: begin
        res_valid = 1'b1;
        unique case (rdata_q[1:0])
          DESC_FAULT: begin
            res_pa   = '1;
            res_kind = OUT_FAULT;
          end
          L2_LARGE: begin
            res_pa   = {rdata_q[31:16], va_q[15:0]};
            res_kind = OUT_LARGE;
          end
          L2_SMALL: begin
            res_pa   = {rdata_q[31:12], va_q[11:0]};
            res_kind = OUT_SMALL;
          end
          default: begin
            res_pa   = va_q;
            res_kind = OUT_PASS;
          end
        endcase
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q <= va_d;
  end

  // Descriptor store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_addr] <= qhead_i.head.word;
    end
    if (mem_re) begin
      rdata_q <= store_q[mem_addr];
    end
  end

  // Output register: holds a finished result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      phys_q    <= res_pa;
      outcome_q <= res_kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phys_addr_o = phys_q;
  assign outcome_o   = outcome_q;

endmodule

`default_nettype wire

/* design/two_level_page_table_walk_unit.sv */
// A section, fault or passthrough at the first level needs one store read;
// a coarse descriptor adds a second-level read. A walk holds the single
// store port until its result is taken by the output register, so the next
// item waits; a store write is done from idle. A two-entry queue decouples
// input from the walker. Reset clears the table base, queue and walker; the
// descriptor store is not cleared and must be written before it is walked.
`default_nettype none

module two_level_page_table_walk_unit
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      phys_addr_o,
  output logic [2:0]       outcome_o
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  ptw_entry_t q_entry;
  ptw_qhead_t q_head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  // Front: table base register and item classification.
  ptw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .address_i   (address_i),
    .data_i      (data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry)
  );

  // Short queue between front and back.
  ptw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  // Back: descriptor store and walk sequencer.
  ptw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qhead_i     (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .phys_addr_o (phys_addr_o),
    .outcome_o   (outcome_o)
  );

endmodule

`default_nettype wire

/* sim/tb_two_level_page_table_walk_unit.sv */
module tb_two_level_page_table_walk_unit;
  import ptw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One input item as queued for the sender, with an optional typed-in answer.
  typedef struct packed {
    logic        mode;
    logic [31:0] address;
    logic [31:0] data;
    logic        has_literal;
    logic [31:0] literal_pa;
    outcome_e    literal_kind;
  } ptw_req_t;

  // One translation result.
  typedef struct packed {
    logic [31:0] pa;
    outcome_e    kind;
  } xlat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        mode_i;
  logic [31:0] address_i;
  logic [31:0] data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] phys_addr_o;
  logic [2:0]  outcome_o;

  // Descriptor store as the walker sees it, and as the generator plans it.
  logic [31:0] map_words [STORE_WORDS];
  logic [31:0] map_base;
  logic [31:0] plan_words [STORE_WORDS];
  bit          plan_written [STORE_WORDS];
  logic [31:0] plan_base;

  ptw_req_t    request_q [$];
  ptw_req_t    cur_req;
  xlat_t       pending_translations [$];
  xlat_t       oldest_xlat;
  logic [31:0] pred_pa;
  outcome_e    pred_kind;
  int unsigned requests_queued;
  int unsigned requests_accepted;
  int unsigned mismatch_count;

  int          send_idle_pct;
  int          stall_pct;
  logic        receiver_hold;

  // Pools that make walks revisit the same tables.
  logic [11:0] hot_tops [8];
  logic [7:0]  hot_mids [8];
  logic [31:0] hot_bases [4];

  ptw_req_t    directed_rows [24];

  two_level_page_table_walk_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .address_i   (address_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .phys_addr_o (phys_addr_o),
    .outcome_o   (outcome_o)
  );

  always #1 clk_i = ~clk_i;

  // Store word index of a byte address; upper bits wrap, low two are dropped.
  function automatic int unsigned word_index(input logic [31:0] byte_addr);
    return int'(byte_addr[IDX_W+1:2]);
  endfunction

  // Two-level walk over the mirrored store and table base.
  function automatic void walk_translate(input logic [31:0] va, output logic [31:0] pa,
                                         output outcome_e kind);
    logic [31:0] l1;
    logic [31:0] l2;
    l1 = map_words[word_index(map_base + {18'd0, va[31:20], 2'b00})];
    case (l1[1:0])
      DESC_FAULT: begin
        pa = '1;
        kind = OUT_FAULT;
      end
      L1_SECTION: begin
        pa = {l1[31:20], va[19:0]};
        kind = OUT_SECTION;
      end
      L1_COARSE: begin
        l2 = map_words[word_index({l1[31:9], 9'd0} + {22'd0, va[19:12], 2'b00})];
        case (l2[1:0])
          DESC_FAULT: begin
            pa = '1;
            kind = OUT_FAULT;
          end
          L2_LARGE: begin
            pa = {l2[31:16], va[15:0]};
            kind = OUT_LARGE;
          end
          L2_SMALL: begin
            pa = {l2[31:12], va[11:0]};
            kind = OUT_SMALL;
          end
          default: begin
            pa = va;
            kind = OUT_PASS;
          end
        endcase
      end
      default: begin
        pa = va;
        kind = OUT_PASS;
      end
    endcase
  endfunction

  function automatic ptw_req_t store_req(input logic [31:0] addr, input logic [31:0] word);
    return '{MODE_WRITE, addr, word, 1'b0, 32'd0, OUT_FAULT};
  endfunction

  function automatic ptw_req_t walk_req(input logic [31:0] va, input logic [31:0] junk);
    return '{MODE_WALK, va, junk, 1'b0, 32'd0, OUT_FAULT};
  endfunction

  function automatic ptw_req_t walk_req_exp(input logic [31:0] va, input logic [31:0] pa,
                                            input outcome_e kind);
    return '{MODE_WALK, va, 32'd0, 1'b1, pa, kind};
  endfunction

  // Queue an item and keep the generator's view of the store up to date.
  task automatic queue_request(input ptw_req_t req);
    if (req.mode == MODE_WRITE) begin
      plan_words[word_index(req.address)] = req.data;
      plan_written[word_index(req.address)] = 1'b1;
    end
    request_q.push_back(req);
    requests_queued++;
  endtask

  task automatic report_mismatch(input string what, input xlat_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected pa=%h outcome=%0d, got pa=%h outcome=%0d",
               $realtime, what, want.pa, want.kind, phys_addr_o, outcome_o);
    end
  endtask

  // Write the table base while the block is idle.
  task automatic program_table_base(input logic [31:0] base);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    map_base  = base;
    plan_base = base;
  endtask

  // Wait until every item is taken and every translation has come back.
  task automatic wait_drained();
    while (requests_accepted != requests_queued || pending_translations.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly well-formed walks whose tables get written first, plus stray writes.
  task automatic fill_random(input int unsigned n_items);
    int unsigned first;
    logic [31:0] va;
    logic [31:0] l1_addr;
    logic [31:0] l2_addr;
    logic [31:0] desc;
    bit          remap;
    first = requests_queued;
    while (requests_queued - first < n_items) begin
      if ($urandom_range(99) < 12) begin
        queue_request(store_req($urandom, $urandom));
      end else begin
        va = $urandom;
        if ($urandom_range(99) < 60) begin
          va[31:20] = hot_tops[$urandom_range(7)];
          va[19:12] = hot_mids[$urandom_range(7)];
        end
        remap = ($urandom_range(99) < 10);
        forever begin
          l1_addr = plan_base + {18'd0, va[31:20], 2'b00};
          if (remap || !plan_written[word_index(l1_addr)]) begin
            remap = 1'b0;
            desc = $urandom;
            case ($urandom_range(5))
              0: desc[1:0] = DESC_FAULT;
              1: desc[1:0] = L1_SECTION;
              2: desc[1:0] = DESC_PASS;
              default: begin
                desc[1:0] = L1_COARSE;
                if ($urandom_range(99) < 60) desc[31:9] = hot_bases[$urandom_range(3)][31:9];
              end
            endcase
            queue_request(store_req({l1_addr[31:2], 2'($urandom_range(3))}, desc));
            continue;
          end
          desc = plan_words[word_index(l1_addr)];
          if (desc[1:0] != L1_COARSE) break;
          l2_addr = {desc[31:9], 9'd0} + {22'd0, va[19:12], 2'b00};
          if (plan_written[word_index(l2_addr)]) break;
          queue_request(store_req({l2_addr[31:2], 2'($urandom_range(3))}, $urandom));
        end
        queue_request(walk_req(va, $urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] base, input int send_pct, input int stall_p,
                           input int unsigned n_items, input bit long_hold);
    program_table_base(base);
    send_idle_pct = send_pct;
    stall_pct = stall_p;
    fill_random(n_items);
    if (long_hold) begin
      fork
        begin
          receiver_hold <= 1'b1;
          repeat (400) @(posedge clk_i);
          receiver_hold <= 1'b0;
        end
        wait_drained();
      join
    end else begin
      wait_drained();
    end
  endtask

  // Sender: offer queued items, hold them while stalled, accept and predict.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        requests_accepted++;
        if (cur_req.mode == MODE_WRITE) begin
          map_words[word_index(cur_req.address)] = cur_req.data;
        end else if (cur_req.has_literal) begin
          pending_translations.push_back('{cur_req.literal_pa, cur_req.literal_kind});
        end else begin
          walk_translate(cur_req.address, pred_pa, pred_kind);
          pending_translations.push_back('{pred_pa, pred_kind});
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = request_q.pop_front();
          mode_i     <= cur_req.mode;
          address_i  <= cur_req.address;
          data_i     <= cur_req.data;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_translations.size() == 0) begin
        report_mismatch("result with no translation pending", '0);
      end else begin
        oldest_xlat = pending_translations.pop_front();
        if (phys_addr_o !== oldest_xlat.pa || outcome_o !== oldest_xlat.kind) begin
          report_mismatch("translation mismatch", oldest_xlat);
        end
      end
    end
    out_stall_i <= receiver_hold || ($urandom_range(99) < stall_pct);
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    mode_i            = MODE_WRITE;
    address_i         = '0;
    data_i            = '0;
    out_stall_i       = 1'b0;
    receiver_hold     = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    requests_queued   = 0;
    requests_accepted = 0;
    mismatch_count    = 0;
    map_base          = '0;
    plan_base         = '0;
    foreach (map_words[i]) map_words[i] = '0;
    foreach (plan_written[i]) plan_written[i] = 1'b0;
    foreach (hot_tops[i]) hot_tops[i] = 12'($urandom);
    foreach (hot_mids[i]) hot_mids[i] = 8'($urandom);
    foreach (hot_bases[i]) hot_bases[i] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the table at address zero: every descriptor type at
    // both levels, field extremes, store index wrap, masked and wrapping
    // coarse table bases.
    program_table_base(32'h0000_0000);
    directed_rows = '{
      store_req(32'h0000_0000, 32'h0000_0000),
      walk_req_exp(32'h0000_0000, 32'hFFFF_FFFF, OUT_FAULT),
      store_req(32'h0000_3FFC, 32'hFFF0_0002),
      walk_req_exp(32'hFFFF_FFFF, 32'hFFFF_FFFF, OUT_SECTION),
      store_req(32'h0000_0004, 32'h0000_0003),
      walk_req_exp(32'h0012_3456, 32'h0012_3456, OUT_PASS),
      store_req(32'h0000_0008, 32'h0000_4001),
      store_req(32'h0000_40D0, 32'hABCD_0001),
      walk_req_exp(32'h0023_4567, 32'hABCD_4567, OUT_LARGE),
      store_req(32'h0000_40D4, 32'h1234_5002),
      walk_req_exp(32'h0023_5ABC, 32'h1234_5ABC, OUT_SMALL),
      store_req(32'h0000_40D8, 32'hFFFF_FFFC),
      walk_req_exp(32'h0023_6000, 32'hFFFF_FFFF, OUT_FAULT),
      store_req(32'h0000_40DC, 32'h0000_0003),
      walk_req_exp(32'h0023_7FFF, 32'h0023_7FFF, OUT_PASS),
      // High address bits wrap onto the entry for the second megabyte.
      store_req(32'hFFFF_0007, 32'h5550_0002),
      walk_req(32'h001F_FFFF, 32'hFFFF_FFFF),
      // Coarse descriptor with junk in the bits below the table base.
      store_req(32'h0000_000C, 32'h0000_41FD),
      walk_req(32'h0033_4000, 32'h0000_0000),
      // Coarse table at the top of the address space wraps to the bottom.
      store_req(32'h0000_0010, 32'hFFFF_FE01),
      store_req(32'h0000_01FC, 32'hFFFF_F002),
      walk_req(32'h004F_F123, 32'h5A5A_A5A5),
      store_req(32'hFFFF_FFFF, 32'hFFFF_FFFF),
      walk_req_exp(32'h0000_0000, 32'hFFFF_FFFF, OUT_FAULT)
    };
    foreach (directed_rows[i]) queue_request(directed_rows[i]);
    wait_drained();

    // Random phases over several table bases, including unaligned ones.
    run_phase(32'hFFFF_FFFF, 0, 0, 330, 1'b0);
    run_phase({18'($urandom_range(32'h3FFFF)), 14'd0}, 74, 0, 330, 1'b0);
    run_phase($urandom, 0, 74, 330, 1'b1);
    run_phase(32'hFFFF_C000, 7, 7, 330, 1'b0);
    run_phase($urandom, 7, 7, 330, 1'b0);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ptw_pkg.sv
design/ptw_front.sv
design/ptw_queue.sv
design/ptw_back.sv
design/two_level_page_table_walk_unit.sv
sim/tb_two_level_page_table_walk_unit.sv
